// ===== sv/cnv3_pkg.sv =====
`default_nettype none
package cnv3_pkg;

	localparam int Taps = 9;

	// register map, index = paddr[5:3]
	localparam logic [2:0] REG_KROW_TOP = 3'd0;
	localparam logic [2:0] REG_KROW_MID = 3'd1;
	localparam logic [2:0] REG_KROW_BOT = 3'd2;
	localparam logic [2:0] REG_WIDTH    = 3'd3;
	localparam logic [2:0] REG_HEIGHT   = 3'd4;

	localparam logic [47:0] KROW_MID_RESET = 48'h0000_0100_0000;
	localparam logic [10:0] WIDTH_RESET    = 11'd640;
	localparam logic [12:0] HEIGHT_RESET   = 13'd480;

	typedef struct packed {
		logic [Taps-1:0][7:0] px;
		logic                 last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== sv/cnv3_front.sv =====
`default_nettype none
module cnv3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  opcode,
	input  wire [7:0]            pixel,
	input  wire [10:0]           image_width,
	input  wire [12:0]           image_height,
	input  cnv3_pkg::q_stat_t    q_stat,
	output logic                 push,
	output cnv3_pkg::job_t       push_job
);
	import cnv3_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	localparam logic [1:0] F_CLEAR = 2'd0;
	localparam logic [1:0] F_IDLE  = 2'd1;
	localparam logic [1:0] F_EXEC  = 2'd2;
	localparam logic [1:0] F_PUSH  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] clr_q;
	logic [CW-1:0] cc_q;
	logic [12:0]   rc_q;
	logic [Taps-1:0][7:0] win_q;

	logic [7:0] mem_a [MAX_WIDTH];
	logic [7:0] mem_b [MAX_WIDTH];
	logic [7:0] rd_a_q, rd_b_q;

	logic [CW-1:0] c_s1;
	logic [12:0]   r_s1;
	logic [7:0]    cur_s1;
	logic          flush_s1, lastcol_s1;
	logic          job0_q, job1_q;
	logic          cge1_q, cge2_q, flush_q;

	logic [31:0]   wl, weff32;
	logic [CW:0]   weff;
	logic [CW-1:0] c;
	logic [12:0]   heff, r;
	logic          flush, lastcol;

	logic          we;
	logic [CW-1:0] wa;
	logic [7:0]    wd_a, wd_b;
	logic [7:0]    up1, up2;

	always_comb begin
		wl     = (image_width == 11'd0) ? 32'd1 : {21'd0, image_width};
		weff32 = (wl > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : wl;
		weff   = weff32[CW:0];
		if ({1'b0, cc_q} >= weff) begin
			c = CW'(weff - 1'b1);
		end else begin
			c = cc_q;
		end
		heff    = (image_height == 13'd0) ? 13'd1 : image_height;
		r       = (rc_q > heff) ? heff : rc_q;
		flush   = (r >= heff);
		lastcol = ({1'b0, c} == weff - 1'b1);
	end

	assign in_ready = (state_q == F_IDLE);

	assign up1 = (r_s1 >= 13'd1) ? rd_a_q : 8'd0;
	assign up2 = (r_s1 >= 13'd2) ? rd_b_q : 8'd0;

	always_comb begin
		we   = 1'b0;
		wa   = c_s1;
		wd_a = cur_s1;
		wd_b = rd_a_q;
		if (state_q == F_CLEAR) begin
			we   = 1'b1;
			wa   = clr_q;
			wd_a = 8'd0;
			wd_b = 8'd0;
		end else if (state_q == F_EXEC) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[wa] <= wd_a;
			mem_b[wa] <= wd_b;
		end
		rd_a_q <= mem_a[c];
		rd_b_q <= mem_b[c];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_s1       <= c;
			r_s1       <= r;
			cur_s1     <= (opcode || flush) ? 8'd0 : pixel;
			flush_s1   <= flush;
			lastcol_s1 <= lastcol;
		end
	end

	// emitted windows
	always_comb begin
		push_job = '0;
		for (int k = 0; k < 3; k++) begin
			if (job0_q) begin
				push_job.px[3*k]   = cge2_q ? win_q[3*k] : 8'd0;
				push_job.px[3*k+1] = win_q[3*k+1];
				push_job.px[3*k+2] = win_q[3*k+2];
			end else begin
				push_job.px[3*k]   = cge1_q ? win_q[3*k+1] : 8'd0;
				push_job.px[3*k+1] = win_q[3*k+2];
				push_job.px[3*k+2] = 8'd0;
			end
		end
		push_job.last = !job0_q && flush_q;
	end

	assign push = (state_q == F_PUSH) && (job0_q || job1_q) && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			clr_q   <= '0;
			cc_q    <= '0;
			rc_q    <= '0;
			win_q   <= '0;
			job0_q  <= 1'b0;
			job1_q  <= 1'b0;
			cge1_q  <= 1'b0;
			cge2_q  <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				F_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(MAX_WIDTH - 1)) begin
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_EXEC;
					end
				end
				F_EXEC: begin
					for (int k = 0; k < 3; k++) begin
						win_q[3*k]   <= win_q[3*k+1];
						win_q[3*k+1] <= win_q[3*k+2];
					end
					win_q[2] <= up2;
					win_q[5] <= up1;
					win_q[8] <= cur_s1;
					job0_q   <= (r_s1 >= 13'd1) && (c_s1 >= CW'(1));
					job1_q   <= (r_s1 >= 13'd1) && lastcol_s1;
					cge1_q   <= (c_s1 >= CW'(1));
					cge2_q   <= (32'(c_s1) >= 32'd2);
					flush_q  <= flush_s1;
					if (lastcol_s1) begin
						cc_q <= '0;
						rc_q <= flush_s1 ? 13'd0 : r_s1 + 13'd1;
					end else begin
						cc_q <= c_s1 + 1'b1;
						rc_q <= r_s1;
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!job0_q && !job1_q) begin
						state_q <= F_IDLE;
					end else if (!q_stat.full) begin
						if (job0_q) begin
							job0_q <= 1'b0;
						end else begin
							job1_q <= 1'b0;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/cnv3_queue.sv =====
`default_nettype none
module cnv3_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  cnv3_pkg::job_t     push_job,
	input  wire                pop,
	output cnv3_pkg::job_t     pop_job,
	output cnv3_pkg::q_stat_t  q_stat
);
	import cnv3_pkg::*;

	job_t       ent_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign pop_job      = ent_q[rp_q];
	assign q_stat.full  = (cnt_q == 3'd4);
	assign q_stat.empty = (cnt_q == 3'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/cnv3_back.sv =====
`default_nettype none
module cnv3_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  cnv3_pkg::q_stat_t        q_stat,
	input  cnv3_pkg::job_t           pop_job,
	output logic                     pop,
	input  wire [cnv3_pkg::Taps-1:0][15:0] taps,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [7:0]               filtered,
	output logic                     last
);
	import cnv3_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MAC  = 3'd1;
	localparam logic [2:0] B_ABS  = 3'd2;
	localparam logic [2:0] B_DIV  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]         state_q;
	job_t               job_q;
	logic [3:0]         idx_q;
	logic signed [24:0] prod_q;
	logic signed [20:0] s_q, n_q;
	logic [18:0]        an_q, rem_q;
	logic [26:0]        dvd_q;
	logic [7:0]         quo_q;
	logic [4:0]         step_q;

	logic signed [24:0] padj;
	logic signed [15:0] tcur;
	logic [7:0]         pcur;
	logic signed [20:0] s_abs, n_abs;
	logic [19:0]        rem_sh;
	logic               ge;
	logic               load;

	assign tcur   = $signed(taps[idx_q[3:0] < 4'd9 ? idx_q : 4'd0]);
	assign pcur   = job_q.px[idx_q < 4'd9 ? idx_q : 4'd0];
	assign padj   = prod_q + (prod_q[24] ? 25'sd255 : 25'sd0);
	assign s_abs  = s_q[20] ? -s_q : s_q;
	assign n_abs  = n_q[20] ? -n_q : n_q;
	assign rem_sh = {rem_q, dvd_q[26]};
	assign ge     = rem_sh >= {1'b0, an_q};
	assign pop    = (state_q == B_IDLE) && !q_stat.empty;
	assign load   = (state_q == B_OUT) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (load) begin
			filtered <= quo_q;
			last     <= job_q.last;
		end
		case (state_q)
			B_MAC: begin
				if (idx_q < 4'd9) begin
					prod_q <= $signed({1'b0, pcur}) * tcur;
					n_q    <= n_q + {{5{tcur[15]}}, tcur};
				end
				if (idx_q != 4'd0) begin
					s_q <= s_q + {{4{padj[24]}}, padj[24:8]};
				end
			end
			B_ABS: begin
				if (n_q > -21'sd256 && n_q < 21'sd256) begin
					an_q <= 19'd256;
				end else begin
					an_q <= n_abs[18:0];
				end
				dvd_q <= {s_abs[18:0], 8'd0};
				rem_q <= '0;
			end
			B_DIV: begin
				rem_q <= ge ? 19'(rem_sh - {1'b0, an_q}) : rem_sh[18:0];
				dvd_q <= {dvd_q[25:0], 1'b0};
				quo_q <= {quo_q[6:0], ge};
			end
			default: begin
				s_q <= '0;
				n_q <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			idx_q     <= '0;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					if (pop) begin
						state_q <= B_MAC;
					end
				end
				B_MAC: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd9) begin
						state_q <= B_ABS;
					end
				end
				B_ABS: begin
					step_q  <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd26) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/conv3x3_zero_pad_norm.sv =====
`default_nettype none
// 3x3 convolution with a zero border over an 8-bit raster stream. Send pixels
// row by row (opcode 0), then one row of flush beats (opcode 1) to push out
// the last image row; the beat marked last is output (height-1, width-1).
// Taps are signed Q8.8, three per kernel-row register, tap m in bits
// 16m+15:16m; each product is truncated toward zero, and the sum is scaled by
// 256/|N|, N being the tap sum (taken as 1.0 when |N| < 1.0); filtered keeps
// the low eight bits. Operation: after reset the line stores are cleared
// with in_ready low. The front takes a new input beat only once it is done
// with the last one: the accept with its line-store read, the window update,
// a push of each output window into a four-deep queue, and a closing step;
// a full queue holds it longer. The back handles one output beat at a time:
// a pop, a pass of the nine taps through one shared multiplier, a step for
// the magnitudes, a 27-step restoring divider (one quotient bit per cycle)
// and a load of the output. Configure through APB only while idle; registers
// sit at 8-byte steps.
module conv3x3_zero_pad_norm #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [5:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         opcode,
	input  wire  [7:0]  pixel,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  filtered,
	output logic        last
);
	import cnv3_pkg::*;

	logic [47:0] krow_top_q, krow_mid_q, krow_bot_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  reg_idx;
	logic        wr;

	q_stat_t              q_stat;
	job_t                 push_job, pop_job;
	logic                 push, pop;
	logic [Taps-1:0][15:0] taps;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr      = psel && penable && pwrite;

	// hold config; write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_top_q <= '0;
			krow_mid_q <= KROW_MID_RESET;
			krow_bot_q <= '0;
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
		end else if (wr) begin
			case (reg_idx)
				REG_KROW_TOP: krow_top_q <= pwdata[47:0];
				REG_KROW_MID: krow_mid_q <= pwdata[47:0];
				REG_KROW_BOT: krow_bot_q <= pwdata[47:0];
				REG_WIDTH:    width_q    <= pwdata[10:0];
				REG_HEIGHT:   height_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KROW_TOP: prdata = {16'd0, krow_top_q};
			REG_KROW_MID: prdata = {16'd0, krow_mid_q};
			REG_KROW_BOT: prdata = {16'd0, krow_bot_q};
			REG_WIDTH:    prdata = {53'd0, width_q};
			REG_HEIGHT:   prdata = {51'd0, height_q};
			default:      prdata = '0;
		endcase
	end

	// unpack taps: index 3*row + column
	always_comb begin
		for (int m = 0; m < 3; m++) begin
			taps[m]   = krow_top_q[16*m +: 16];
			taps[3+m] = krow_mid_q[16*m +: 16];
			taps[6+m] = krow_bot_q[16*m +: 16];
		end
	end

	cnv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.pixel        (pixel),
		.image_width  (width_q),
		.image_height (height_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	cnv3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	cnv3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_job   (pop_job),
		.pop       (pop),
		.taps      (taps),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.last      (last)
	);
endmodule
`default_nettype wire

// ===== sv/cnv3_checker.sv =====
`default_nettype none
module cnv3_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       pready,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] filtered,
	input wire       last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(last))
		else $error("output beat changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input beat taken on back-to-back cycles");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({filtered, last}))
		else $error("output beat carries unknown bits");
endmodule

bind conv3x3_zero_pad_norm cnv3_checker u_cnv3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered),
	.last      (last)
);
`default_nettype wire

// ===== tb/sv/tb_conv3x3_zero_pad_norm.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_conv3x3_zero_pad_norm;
	import cnv3_pkg::*;

	localparam int       WMAX        = 1024;
	localparam int       CYCLE_LIMIT = 4_000_000;
	localparam int       SETTLE      = 300;
	localparam logic     OP_PIXEL    = 1'b0;
	localparam logic     OP_FLUSH    = 1'b1;

	typedef struct packed {
		logic [7:0] filtered;
		logic       last;
	} pix_beat_t;

	// Golden image pipeline plus the store of outstanding output beats.
	class frame_scoreboard;
		logic [47:0] krow [3];
		logic [10:0] width_reg;
		logic [12:0] height_reg;
		logic [7:0]  prev_row [WMAX];
		logic [7:0]  prev2_row [WMAX];
		logic [7:0]  win [9];
		int unsigned row_cnt, col_cnt;
		pix_beat_t   due [$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			krow[0] = '0;
			krow[1] = KROW_MID_RESET;
			krow[2] = '0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (prev_row[i]) begin
				prev_row[i] = '0;
				prev2_row[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			row_cnt = 0;
			col_cnt = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_KROW_TOP: krow[0] = val[47:0];
				REG_KROW_MID: krow[1] = val[47:0];
				REG_KROW_BOT: krow[2] = val[47:0];
				REG_WIDTH: width_reg = val[10:0];
				REG_HEIGHT: height_reg = val[12:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > WMAX) return WMAX;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function bit in_flush_row();
			return row_cnt >= eff_height();
		endfunction

		function logic [7:0] apply_kernel(logic [7:0] px [9]);
			int s, nsum, t;
			logic signed [15:0] raw;
			longint unsigned mag_s, mag_n;
			s = 0;
			nsum = 0;
			for (int k = 0; k < 3; k++)
				for (int m = 0; m < 3; m++) begin
					raw = krow[k][16*m +: 16];
					t = raw;
					s += (int'(px[3*k+m]) * t) / 256;
					nsum += t;
				end
			if (nsum > -256 && nsum < 256) nsum = 256;
			mag_s = (s < 0) ? -s : s;
			mag_n = (nsum < 0) ? -nsum : nsum;
			return 8'((mag_s * 256) / mag_n);
		endfunction

		function void note_pixel(logic op, logic [7:0] pix);
			int unsigned w, h, c, r;
			logic [7:0] cur, up1, up2;
			logic [7:0] px [9];
			bit flush, lastcol;
			w = eff_width();
			h = eff_height();
			c = (col_cnt >= w) ? w - 1 : col_cnt;
			r = (row_cnt > h) ? h : row_cnt;
			flush = r >= h;
			cur = (op == OP_FLUSH || flush) ? 8'd0 : pix;
			up1 = (r >= 1) ? prev_row[c] : 8'd0;
			up2 = (r >= 2) ? prev2_row[c] : 8'd0;
			for (int k = 0; k < 3; k++) begin
				win[3*k] = win[3*k+1];
				win[3*k+1] = win[3*k+2];
			end
			win[2] = up2;
			win[5] = up1;
			win[8] = cur;
			prev2_row[c] = prev_row[c];
			prev_row[c] = cur;
			lastcol = (c == w - 1);
			if (r >= 1) begin
				if (c >= 1) begin
					for (int k = 0; k < 3; k++) begin
						px[3*k] = (c >= 2) ? win[3*k] : 8'd0;
						px[3*k+1] = win[3*k+1];
						px[3*k+2] = win[3*k+2];
					end
					due.push_back('{apply_kernel(px), 1'b0});
				end
				if (lastcol) begin
					for (int k = 0; k < 3; k++) begin
						px[3*k] = (c >= 1) ? win[3*k+1] : 8'd0;
						px[3*k+1] = win[3*k+2];
						px[3*k+2] = 8'd0;
					end
					due.push_back('{apply_kernel(px), flush});
				end
			end
			if (lastcol) begin
				col_cnt = 0;
				row_cnt = flush ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
				row_cnt = r;
			end
		endfunction

		function void check_beat(logic [7:0] f, logic l);
			pix_beat_t exp_beat;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output beat filtered=%0d last=%0b", f, l);
				return;
			end
			exp_beat = due.pop_front();
			if (exp_beat.filtered !== f || exp_beat.last !== l) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
						exp_beat.filtered, f, exp_beat.last, l);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_ready, opcode;
	logic [7:0]  pixel;
	logic        out_valid, out_ready;
	logic [7:0]  filtered;
	logic        last;

	frame_scoreboard sb = new();
	int  cycles = 0;
	int  items_sent = 0;
	bit  gaps_on = 1'b1;     // random idling on both sides
	bit  rx_long_req = 1'b0; // ask the receiver for one long hold-off
	int  stall_left = 0;

	conv3x3_zero_pad_norm DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .pixel(pixel),
		.out_valid(out_valid), .out_ready(out_ready), .filtered(filtered), .last(last)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("conv3x3_zero_pad_norm regression: fail");
			$finish;
		end
	end

	// Check every output beat at the edge that accepts it.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_beat(filtered, last);

	// Receiver back-pressure: one assignment to out_ready per falling edge.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_long_req) begin
				// long hold-off so the output queue and the front both back up
				rx_long_req = 1'b0;
				stall_left = 700;
				out_ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Register write: setup cycle then access cycle; call at a falling edge.
	task automatic apb_write(logic [2:0] idx, logic [63:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [10:0] w, logic [12:0] h,
			logic [47:0] k0, logic [47:0] k1, logic [47:0] k2);
		apb_write(REG_KROW_TOP, {16'd0, k0});
		apb_write(REG_KROW_MID, {16'd0, k1});
		apb_write(REG_KROW_BOT, {16'd0, k2});
		apb_write(REG_WIDTH, {53'd0, w});
		apb_write(REG_HEIGHT, {51'd0, h});
	endtask

	// Offer one beat, hold it until accepted, then maybe idle for a burst.
	task automatic send_beat(logic op, logic [7:0] pix);
		in_valid <= 1'b1;
		opcode <= op;
		pixel <= pix;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(op, pix);
		items_sent++;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// Mostly well-formed: pixels inside the image, flush beats on the border row;
	// noise_pct of the beats take the other opcode.
	task automatic feed(int count, int noise_pct);
		logic op;
		for (int i = 0; i < count; i++) begin
			op = sb.in_flush_row() ? OP_FLUSH : OP_PIXEL;
			if ($urandom_range(0, 99) < noise_pct) op = ~op;
			send_beat(op, 8'($urandom));
		end
	endtask

	task automatic finish_frame(int noise_pct);
		do feed(1, noise_pct); while (sb.row_cnt != 0 || sb.col_cnt != 0);
	endtask

	// Hold the sender until every expected beat is back, then let the front settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [47:0] rand_taps();
		logic [47:0] k;
		case ($urandom_range(0, 3))
			0: k = {16'($urandom), 32'($urandom)};
			1: for (int m = 0; m < 3; m++) k[16*m +: 16] = 16'($urandom_range(0, 768) - 384);
			2: k = {3{16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)}};
			default: for (int m = 0; m < 3; m++) k[16*m +: 16] = 16'($urandom_range(0, 96));
		endcase
		return k;
	endfunction

	initial begin
		int phase_no;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_PIXEL;
		pixel = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: extreme taps and pixels on a 3x2 frame
		configure(11'd3, 13'd2, 48'h0100_8000_7FFF, 48'h7FFF_0100_8000, 48'h8000_7FFF_0100);
		send_beat(OP_PIXEL, 8'd255);
		send_beat(OP_PIXEL, 8'd0);
		send_beat(OP_PIXEL, 8'd255);
		send_beat(OP_FLUSH, 8'd255); // flush inside the image
		send_beat(OP_PIXEL, 8'd255);
		send_beat(OP_PIXEL, 8'd128);
		send_beat(OP_PIXEL, 8'd255); // pixel on the border row
		send_beat(OP_FLUSH, 8'd0);
		send_beat(OP_FLUSH, 8'd1);
		drain();
		// single pixel frame, then zero width and height registers
		configure(11'd1, 13'd1, 48'h0, 48'h0000_0100_0000, 48'h0);
		send_beat(OP_PIXEL, 8'd200);
		send_beat(OP_FLUSH, 8'd0);
		drain();
		configure(11'd0, 13'd0, 48'h0080_0080_0080, 48'h0080_0080_0080, 48'h0080_0080_0080);
		send_beat(OP_PIXEL, 8'd77);
		send_beat(OP_FLUSH, 8'd0);
		drain();
		// tall image, then shrink the height mid-image
		configure(11'd2, 13'd8191, rand_taps(), rand_taps(), rand_taps());
		feed(8, 0);
		drain();
		apb_write(REG_HEIGHT, 64'd2);
		finish_frame(0);
		drain();
		// shrink the width mid-row
		configure(11'd8, 13'd3, rand_taps(), rand_taps(), rand_taps());
		feed(13, 0);
		drain();
		apb_write(REG_WIDTH, 64'd3);
		finish_frame(0);
		drain();

		// random frames, mostly small; one oversized width register, fed only
		// for part of a row so the item count stays bounded
		phase_no = 0;
		while (items_sent < 900) begin
			if (items_sent > 750) gaps_on = 1'b0;
			if (phase_no == 3)
				configure(11'd2047, 13'd1, rand_taps(), rand_taps(), rand_taps());
			else
				configure(11'($urandom_range(1, 12)), 13'($urandom_range(1, 6)),
					rand_taps(), rand_taps(), rand_taps());
			if (phase_no == 2) rx_long_req = 1'b1;
			if (phase_no == 3 || $urandom_range(0, 3) == 0) begin
				// leave a partial frame behind for the next settings
				feed($urandom_range(1, 30), 3);
			end else begin
				finish_frame(($urandom_range(0, 2) == 0) ? 8 : 0);
				if ($urandom_range(0, 1) == 0) finish_frame(0);
			end
			drain();
			phase_no++;
		end
		// close any open frame with no idling
		finish_frame(0);
		drain();

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("conv3x3_zero_pad_norm regression: pass");
		else
			$display("conv3x3_zero_pad_norm regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
